[rtl/core/grq_pkg.sv]
`default_nettype none

package grq_pkg;

  // Fixed field widths of the request and configuration interfaces.
  localparam int unsigned VERTEX_W = 5;
  localparam int unsigned COUNT_W  = 6;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  // Request type codes as they arrive on the input channel.
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_QUERY = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Result status codes.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified commands handed from the front to the back.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_QUERY,
    OP_CLEAR,
    OP_ERROR
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e             op;
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/core/graph_reachability_query_core.sv]
`default_nettype none

// Directed-graph reachability engine over an adjacency bit matrix.
// Input channel (in_valid_i/in_ready_o) takes one request per transaction:
// add an arc, clear the graph, or ask whether target is reachable from source.
// Output channel (out_valid_o/out_ready_i) returns one transaction per query
// with reachable_o and status_o; add, clear and unknown requests return none.
// cfg_we_i/cfg_wdata_i write vertex_count, the number of vertices in use.
// The front classifies requests into a two-entry command queue, so up to two
// kept requests wait while the back is busy; dropped requests are taken
// whenever the queue has room. Commands reach the back through the queue.
// Add arc: a row read, then a merged row write.
// Clear and out-of-range query: handled in the idle state alone.
// Query: the back sweeps rows 0..L-1 of the adjacency RAM, one read per cycle,
// where L is the active vertex limit. Sweeps repeat until one sweep adds no
// vertex, and each sweep reads its rows one at a time through the single
// read port of the adjacency RAM.
// Reset empties the graph at once through per-row valid bits, with no
// clearing pass, and sets vertex_count to 32.
// A stalled receiver holds the result register; the back takes no further
// command until it is taken, while the queue keeps accepting until full.
module graph_reachability_query_core #(
  parameter int unsigned NUM_VERTICES = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [grq_pkg::COUNT_W-1:0]    cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [grq_pkg::VERTEX_W-1:0]   source_vertex_i,
  input  wire logic [grq_pkg::VERTEX_W-1:0]   target_vertex_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                reachable_o,
  output logic                                status_o
);

  import grq_pkg::*;

  localparam int unsigned LIM_W = $clog2(NUM_VERTICES + 1);

  logic [COUNT_W-1:0] vertex_count_q;
  logic [LIM_W-1:0]   lim;
  logic               push_valid, push_ready;
  cmd_t               push_cmd;
  logic               pop_valid, pop_ready;
  cmd_t               pop_cmd;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  // Active limit is the smaller of vertex_count and the graph size.
  assign lim = (32'(vertex_count_q) < NUM_VERTICES) ? LIM_W'(vertex_count_q)
                                                    : LIM_W'(NUM_VERTICES);

  grq_front #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .source_vertex_i (source_vertex_i),
    .target_vertex_i (target_vertex_i),
    .lim_i           (lim),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  grq_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  grq_back #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lim_i       (lim),
    .cmd_valid_i (pop_valid),
    .cmd_ready_o (pop_ready),
    .cmd_i       (pop_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .reachable_o (reachable_o),
    .status_o    (status_o)
  );

  // An out-of-range result never reports a path.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_RANGE)) |-> !reachable_o)
    else $error("range error reported with reachable set");

  // The back only takes a command while the result register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ready |-> !out_valid_o)
    else $error("back took a command while a result was pending");

  // A full queue that refuses input must hold work for the back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> pop_valid)
    else $error("input stalled with an empty command queue");

endmodule

`default_nettype wire

[rtl/core/grq_ram.sv]
`default_nettype none

module grq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/core/grq_queue.sv]
`default_nettype none

module grq_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire grq_pkg::cmd_t push_cmd_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output grq_pkg::cmd_t      pop_cmd_o
);

  import grq_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointer and fill-count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage carries payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/grq_front.sv]
`default_nettype none

module grq_front #(
  parameter int unsigned NUM_VERTICES = 32
) (
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [1:0]                           req_type_i,
  input  wire logic [grq_pkg::VERTEX_W-1:0]         source_vertex_i,
  input  wire logic [grq_pkg::VERTEX_W-1:0]         target_vertex_i,
  input  wire logic [$clog2(NUM_VERTICES+1)-1:0]    lim_i,
  output logic                                      push_valid_o,
  input  wire logic                                 push_ready_i,
  output grq_pkg::cmd_t                             push_cmd_o
);

  import grq_pkg::*;

  logic ok;
  logic keep;

  // Both indices must fall below the active vertex limit.
  assign ok = (32'(source_vertex_i) < 32'(lim_i)) && (32'(target_vertex_i) < 32'(lim_i));

  // Classify the request; ignored requests are taken and dropped here.
  always_comb begin
    keep          = 1'b0;
    push_cmd_o.op = OP_ADD;
    push_cmd_o.src = source_vertex_i;
    push_cmd_o.dst = target_vertex_i;
    unique case (req_type_i)
      REQ_ADD: begin
        keep          = ok;
        push_cmd_o.op = OP_ADD;
      end
      REQ_QUERY: begin
        keep          = 1'b1;
        push_cmd_o.op = ok ? OP_QUERY : OP_ERROR;
      end
      REQ_CLEAR: begin
        keep          = 1'b1;
        push_cmd_o.op = OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && keep;

endmodule

`default_nettype wire

[rtl/core/grq_back.sv]
`default_nettype none

module grq_back #(
  parameter int unsigned NUM_VERTICES = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic [$clog2(NUM_VERTICES+1)-1:0] lim_i,
  input  wire logic                              cmd_valid_i,
  output logic                                   cmd_ready_o,
  input  wire grq_pkg::cmd_t                     cmd_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   reachable_o,
  output logic                                   status_o
);

  import grq_pkg::*;

  localparam int unsigned VW    = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned LIM_W = $clog2(NUM_VERTICES + 1);

  localparam int unsigned ST_W      = 2;
  localparam logic [ST_W-1:0] ST_IDLE   = 2'd0;
  localparam logic [ST_W-1:0] ST_ADD_WR = 2'd1;
  localparam logic [ST_W-1:0] ST_QUERY  = 2'd2;

  logic [ST_W-1:0]         state_q, state_d;
  logic [VW-1:0]           src_q, src_d;
  logic [VW-1:0]           dst_q, dst_d;
  logic [LIM_W-1:0]        idx_q, idx_d;
  logic                    pend_q, pend_d;
  logic [VW-1:0]           pend_idx_q, pend_idx_d;
  logic                    sweep_chg_q, sweep_chg_d;
  logic [NUM_VERTICES-1:0] visited_q, visited_d;
  logic [NUM_VERTICES-1:0] row_valid_q, row_valid_d;
  logic                    res_valid_q, res_valid_d;
  logic                    res_reach_q, res_reach_d;
  logic                    res_status_q, res_status_d;

  logic                    ram_re;
  logic [VW-1:0]           ram_raddr;
  logic                    ram_we;
  logic [NUM_VERTICES-1:0] ram_wdata;
  logic [NUM_VERTICES-1:0] ram_rdata;

  logic [VW-1:0]           cmd_src;
  logic [VW-1:0]           cmd_dst;
  logic [NUM_VERTICES-1:0] lim_mask;
  logic [NUM_VERTICES-1:0] add_row;
  logic [NUM_VERTICES-1:0] qry_row;
  logic [NUM_VERTICES-1:0] new_bits;
  logic                    last_row;

  grq_ram #(
    .WIDTH (NUM_VERTICES),
    .DEPTH (NUM_VERTICES)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (src_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cmd_src = VW'(cmd_i.src);
  assign cmd_dst = VW'(cmd_i.dst);

  // Bits of vertices below the active limit.
  always_comb begin
    for (int i = 0; i < NUM_VERTICES; i++) begin
      lim_mask[i] = (i < 32'(lim_i));
    end
  end

  // Rows never written since reset or the last clear read as empty.
  assign add_row  = row_valid_q[src_q] ? ram_rdata : '0;
  assign qry_row  = row_valid_q[pend_idx_q] ? ram_rdata : '0;
  assign new_bits = visited_q[pend_idx_q] ? (qry_row & lim_mask & ~visited_q) : '0;
  assign last_row = ((LIM_W'(pend_idx_q) + 1'b1) == lim_i);

  assign cmd_ready_o = (state_q == ST_IDLE) && !res_valid_q;

  // Command sequencer: edge insert, graph clear, range-error result and sweep-based closure.
  always_comb begin
    state_d      = state_q;
    src_d        = src_q;
    dst_d        = dst_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    sweep_chg_d  = sweep_chg_q;
    visited_d    = visited_q;
    row_valid_d  = row_valid_q;
    res_valid_d  = res_valid_q;
    res_reach_d  = res_reach_q;
    res_status_d = res_status_q;
    ram_re       = 1'b0;
    ram_raddr    = cmd_src;
    ram_we       = 1'b0;
    ram_wdata    = add_row | (NUM_VERTICES'(1) << dst_q);

    if (res_valid_q && out_ready_i) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          src_d = cmd_src;
          dst_d = cmd_dst;
          unique case (cmd_i.op)
            OP_ADD: begin
              ram_re    = 1'b1;
              ram_raddr = cmd_src;
              state_d   = ST_ADD_WR;
            end
            OP_QUERY: begin
              visited_d   = NUM_VERTICES'(1) << cmd_src;
              idx_d       = '0;
              pend_d      = 1'b0;
              sweep_chg_d = 1'b0;
              state_d     = ST_QUERY;
            end
            OP_CLEAR: begin
              row_valid_d = '0;
              visited_d   = '0;
            end
            OP_ERROR: begin
              res_valid_d  = 1'b1;
              res_reach_d  = 1'b0;
              res_status_d = STATUS_RANGE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_ADD_WR: begin
        // Merge the new arc into the row read in the previous cycle.
        ram_we             = 1'b1;
        row_valid_d[src_q] = 1'b1;
        state_d            = ST_IDLE;
      end
      ST_QUERY: begin
        // Issue one row read per cycle while the sweep has rows left.
        pend_d     = (idx_q < lim_i);
        pend_idx_d = idx_q[VW-1:0];
        if (idx_q < lim_i) begin
          ram_re    = 1'b1;
          ram_raddr = idx_q[VW-1:0];
          idx_d     = idx_q + 1'b1;
        end
        // Fold in the row that arrived this cycle.
        if (pend_q) begin
          visited_d = visited_q | new_bits;
          if (last_row) begin
            if (sweep_chg_q || (new_bits != '0)) begin
              idx_d       = '0;
              sweep_chg_d = 1'b0;
            end else begin
              res_valid_d  = 1'b1;
              res_reach_d  = visited_q[dst_q];
              res_status_d = STATUS_OK;
              state_d      = ST_IDLE;
            end
          end else begin
            sweep_chg_d = sweep_chg_q || (new_bits != '0);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      sweep_chg_q <= 1'b0;
      visited_q   <= '0;
      row_valid_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      sweep_chg_q <= sweep_chg_d;
      visited_q   <= visited_d;
      row_valid_q <= row_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    dst_q        <= dst_d;
    pend_idx_q   <= pend_idx_d;
    res_reach_q  <= res_reach_d;
    res_status_q <= res_status_d;
  end

  assign out_valid_o = res_valid_q;
  assign reachable_o = res_reach_q;
  assign status_o    = res_status_q;

endmodule

`default_nettype wire
